@@ hw/rtl/prst_pkg.sv @@
// Shared types, codes and constants of the pending reply slot table.
// Used by the controller, the datapath, the top level and the checker.
package prst_pkg;

  // Default number of slots in the table.
  localparam int SLOT_COUNT_DEF = 8;

  // Command codes.
  localparam logic [2:0] CMD_ACQUIRE    = 3'd0;
  localparam logic [2:0] CMD_LOOKUP     = 3'd1;
  localparam logic [2:0] CMD_SET_STATUS = 3'd2;
  localparam logic [2:0] CMD_SET_CODE   = 3'd3;
  localparam logic [2:0] CMD_SET_QOS    = 3'd4;
  localparam logic [2:0] CMD_SET_TOPIC  = 3'd5;
  localparam logic [2:0] CMD_FREE       = 3'd6;
  localparam logic [2:0] CMD_READ       = 3'd7;

  // Outcome codes.
  localparam logic [1:0] OUT_DONE  = 2'd0;
  localparam logic [1:0] OUT_RANGE = 2'd1;
  localparam logic [1:0] OUT_MISS  = 2'd2;

  // Slot status codes.
  localparam logic [1:0] SS_AWAIT   = 2'd0;
  localparam logic [1:0] SS_SUCCESS = 2'd1;
  localparam logic [1:0] SS_ERROR   = 2'd2;

  // Input word.
  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         slot_index;
    logic [7:0]         message_type;
    logic [15:0]        message_id;
    logic [1:0]         new_status;
    logic [7:0]         new_return_code;
    logic signed [7:0]  new_granted_qos;
    logic [15:0]        new_topic_id;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]         outcome;
    logic [7:0]         found_slot;
    logic [1:0]         slot_status;
    logic [7:0]         slot_return_code;
    logic signed [7:0]  slot_granted_qos;
    logic [15:0]        slot_topic_id;
  } out_word_t;

  // One row of the slot memory.
  typedef struct packed {
    logic [7:0]         type_code;
    logic [15:0]        msg_id;
    logic [1:0]         status;
    logic [7:0]         ret_code;
    logic signed [7:0]  qos;
    logic [15:0]        topic;
  } row_t;

  // Contents of a slot that was never written or was freed.
  localparam row_t ROW_RESET = '{
    type_code: 8'd0,
    msg_id:    16'd0,
    status:    SS_SUCCESS,
    ret_code:  8'd0,
    qos:       8'sd0,
    topic:     16'd0
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       scan_start;
    logic       scan_step;
    logic       rd_indexed;
    logic       wr_acquire;
    logic       wr_indexed;
    logic       free_slot;
    logic       finish;
    logic [1:0] outcome;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] command;
    logic       in_range;
    logic       chk_valid;
    logic       hit;
    logic       last;
  } sts_t;

endpackage

@@ hw/rtl/pending_reply_slot_table_top.sv @@
// Top level of the pending reply slot table: controller plus datapath.
// Depends on prst_pkg, prst_ctrl and prst_dpath.
//
//   channel  ports                  handshake
//   input    start, busy, in_word   word taken when start is high and busy low
//   result   out_valid, out_word    word shown for one cycle, always taken
//
// Acquire and lookup walk the slots one per cycle through the single read
// port of the slot memory and stop at the first hit or after the last slot.
// Set and read commands read the slot and then write or report it; free and
// out-of-range commands finish straight from dispatch.
// Reset is synchronous and active low; the table comes up with every slot free.
// busy drops in the cycle the result appears, so the next word can follow.
module pending_reply_slot_table_top
  import prst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  ctl_t ctl;
  sts_t sts;

  // Command sequencer.
  prst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Slot storage and result formation.
  prst_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

@@ hw/rtl/prst_ctrl.sv @@
// Command sequencer of the pending reply slot table.
// Depends on prst_pkg for the command, status and code types.
module prst_ctrl
  import prst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_DISPATCH = 4'b0010,
    S_SCAN     = 4'b0100,
    S_MODIFY   = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.outcome = OUT_DONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.command == CMD_ACQUIRE || sts.command == CMD_LOOKUP) begin
          ctl.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else if (!sts.in_range) begin
          ctl.finish = 1'b1;
          ctl.outcome = OUT_RANGE;
          state_nxt = S_IDLE;
        end else if (sts.command == CMD_FREE) begin
          ctl.free_slot = 1'b1;
          ctl.finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctl.rd_indexed = 1'b1;
          state_nxt = S_MODIFY;
        end
      end
      S_SCAN: begin
        if (sts.chk_valid && sts.hit) begin
          ctl.wr_acquire = (sts.command == CMD_ACQUIRE);
          ctl.finish = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.chk_valid && sts.last) begin
          ctl.finish = 1'b1;
          ctl.outcome = OUT_MISS;
          state_nxt = S_IDLE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      S_MODIFY: begin
        ctl.wr_indexed = (sts.command != CMD_READ);
        ctl.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/prst_dpath.sv @@
// Datapath of the pending reply slot table: slot memory, flags, scan and result.
// Depends on prst_pkg for the word, row and command types.
module prst_dpath
  import prst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctl_t      ctl,
  output sts_t      sts,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  in_word_t               cmd_r;
  row_t                   mem_r [SLOT_COUNT];
  row_t                   mem_q_r;
  logic [SLOT_COUNT-1:0]  slot_in_use_r;
  logic [SLOT_COUNT-1:0]  row_valid_r;
  logic [CNT_W-1:0]       rd_idx_r;
  logic                   q_valid_r;
  logic [IDX_W-1:0]       q_idx_r;
  logic                   q_use_r;
  logic                   q_rowv_r;
  logic                   out_valid_r;
  out_word_t              out_word_r;

  logic [IDX_W-1:0]       idx;
  logic                   rd_more;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  row_t                   row_eff;
  row_t                   wr_row;
  out_word_t              res;

  // Command word is held for the whole command.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_word;
    end
  end

  assign idx     = cmd_r.slot_index[IDX_W-1:0];
  assign rd_more = (rd_idx_r < CNT_W'(SLOT_COUNT));
  assign rd_en   = ctl.rd_indexed || (ctl.scan_step && rd_more);
  assign rd_addr = ctl.rd_indexed ? idx : rd_idx_r[IDX_W-1:0];
  assign wr_en   = ctl.wr_acquire || ctl.wr_indexed;
  assign wr_addr = ctl.wr_acquire ? q_idx_r : idx;

  // A row never written since reset or free reads as the cleared row.
  assign row_eff = q_rowv_r ? mem_q_r : ROW_RESET;

  // New row contents for acquire and the set commands.
  always_comb begin
    wr_row = row_eff;
    if (ctl.wr_acquire) begin
      wr_row.type_code = cmd_r.message_type;
      wr_row.msg_id    = cmd_r.message_id;
      wr_row.status    = SS_AWAIT;
    end else begin
      case (cmd_r.command)
        CMD_SET_STATUS: wr_row.status   = cmd_r.new_status;
        CMD_SET_CODE:   wr_row.ret_code = cmd_r.new_return_code;
        CMD_SET_QOS:    wr_row.qos      = cmd_r.new_granted_qos;
        CMD_SET_TOPIC:  wr_row.topic    = cmd_r.new_topic_id;
        default:        wr_row = row_eff;
      endcase
    end
  end

  // Slot memory with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      mem_q_r <= mem_r[rd_addr];
    end
  end

  // Flags sampled alongside the memory read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_idx_r  <= rd_addr;
      q_use_r  <= slot_in_use_r[rd_addr];
      q_rowv_r <= row_valid_r[rd_addr];
    end
  end

  // In-use and row-valid flags, one per slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_in_use_r <= '0;
      row_valid_r   <= '0;
    end else begin
      if (ctl.wr_acquire) begin
        slot_in_use_r[q_idx_r] <= 1'b1;
        row_valid_r[q_idx_r]   <= 1'b1;
      end
      if (ctl.wr_indexed) begin
        row_valid_r[idx] <= 1'b1;
      end
      if (ctl.free_slot) begin
        slot_in_use_r[idx] <= 1'b0;
        row_valid_r[idx]   <= 1'b0;
      end
    end
  end

  // Scan address counter and the check stage behind the read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      q_valid_r <= 1'b0;
    end else if (ctl.scan_start) begin
      rd_idx_r  <= '0;
      q_valid_r <= 1'b0;
    end else if (ctl.scan_step) begin
      q_valid_r <= rd_more;
      if (rd_more) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
    end
  end

  // Status for the controller.
  always_comb begin
    sts.command   = cmd_r.command;
    sts.in_range  = ({1'b0, cmd_r.slot_index} < 9'(SLOT_COUNT));
    sts.chk_valid = q_valid_r;
    sts.last      = (q_idx_r == IDX_W'(SLOT_COUNT - 1));
    if (cmd_r.command == CMD_ACQUIRE) begin
      sts.hit = !q_use_r;
    end else begin
      sts.hit = q_use_r && (row_eff.status == SS_AWAIT) &&
                (row_eff.type_code == cmd_r.message_type) &&
                (row_eff.msg_id == cmd_r.message_id);
    end
  end

  // Result word; fields a command does not define stay zero.
  always_comb begin
    res = '0;
    res.outcome = ctl.outcome;
    if (ctl.outcome == OUT_DONE) begin
      if (cmd_r.command == CMD_ACQUIRE || cmd_r.command == CMD_LOOKUP) begin
        res.found_slot = 8'(q_idx_r);
      end else if (cmd_r.command == CMD_READ) begin
        res.slot_status      = row_eff.status;
        res.slot_return_code = row_eff.ret_code;
        res.slot_granted_qos = row_eff.qos;
        res.slot_topic_id    = row_eff.topic;
      end
    end else if (ctl.outcome == OUT_RANGE && cmd_r.command == CMD_READ) begin
      res.slot_status = SS_ERROR;
    end
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ hw/rtl/prst_checker.sv @@
// Port-level checks for the pending reply slot table, bound to the top level.
// Depends on prst_pkg and pending_reply_slot_table_top.
module prst_checker
  import prst_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // A taken word keeps the block busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after taking a word");

  // Every command passes the dispatch state before it finishes, so strobes never touch.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result only follows a cycle of work.
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a command in flight");

  // Outcome is one of the three defined codes.
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.outcome == OUT_DONE || out_word.outcome == OUT_RANGE ||
                   out_word.outcome == OUT_MISS))
    else $error("undefined outcome code");

  // Failed commands report no slot and no stored context.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.outcome != OUT_DONE) |->
      (out_word.found_slot == 8'd0 && out_word.slot_topic_id == 16'd0))
    else $error("failed command carries slot data");

endmodule

bind pending_reply_slot_table_top prst_checker u_prst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

@@ tb/prst_reply_checker.sv @@
// Checker for the pending reply slot table: watches both channels, predicts each reply word.
// Depends on prst_pkg; instantiated beside the block by pending_reply_slot_table_top_test.
module prst_reply_checker
  import prst_pkg::*;
#(
  parameter int SLOTS = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  output int        mismatches,
  output int        waiting
);

  // Shadow copy of the slot table.
  row_t      tbl_row  [SLOTS];
  logic      tbl_used [SLOTS];
  out_word_t expected_replies [$];
  int        reply_count;

  initial begin
    mismatches  = 0;
    waiting     = 0;
    reply_count = 0;
  end

  // Prints one line per mismatch (the first hundred) and counts all of them.
  task automatic report_mismatch(string what);
    if (mismatches < 100) begin
      $display("%0t: reply word %0d: %s", $time, reply_count, what);
    end
    mismatches = mismatches + 1;
  endtask

  // Applies one command word to the shadow table and returns the reply it should give.
  function automatic out_word_t predict_reply(in_word_t w);
    out_word_t r;
    logic      taken;
    int        k;
    r     = '0;
    taken = 1'b0;
    if (w.command == CMD_ACQUIRE) begin
      // Claim the lowest free slot; the context fields stay as they are.
      r.outcome = OUT_MISS;
      for (k = 0; k < SLOTS && !taken; k++) begin
        if (!tbl_used[k]) begin
          tbl_used[k]          = 1'b1;
          tbl_row[k].type_code = w.message_type;
          tbl_row[k].msg_id    = w.message_id;
          tbl_row[k].status    = SS_AWAIT;
          r.outcome            = OUT_DONE;
          r.found_slot         = k[7:0];
          taken                = 1'b1;
        end
      end
    end else if (w.command == CMD_LOOKUP) begin
      // Lowest used slot that still awaits a reply and matches type and id.
      r.outcome = OUT_MISS;
      for (k = 0; k < SLOTS && !taken; k++) begin
        if (tbl_used[k] && tbl_row[k].status == SS_AWAIT &&
            tbl_row[k].type_code == w.message_type && tbl_row[k].msg_id == w.message_id) begin
          r.outcome    = OUT_DONE;
          r.found_slot = k[7:0];
          taken        = 1'b1;
        end
      end
    end else if (int'(w.slot_index) >= SLOTS) begin
      // An index past the table changes nothing; a read also reports an error status.
      r.outcome = OUT_RANGE;
      if (w.command == CMD_READ) begin
        r.slot_status = SS_ERROR;
      end
    end else begin
      k = int'(w.slot_index);
      r.outcome = OUT_DONE;
      case (w.command)
        CMD_SET_STATUS: tbl_row[k].status   = w.new_status;
        CMD_SET_CODE:   tbl_row[k].ret_code = w.new_return_code;
        CMD_SET_QOS:    tbl_row[k].qos      = w.new_granted_qos;
        CMD_SET_TOPIC:  tbl_row[k].topic    = w.new_topic_id;
        CMD_FREE: begin
          tbl_row[k]  = ROW_RESET;
          tbl_used[k] = 1'b0;
        end
        default: begin
          r.slot_status      = tbl_row[k].status;
          r.slot_return_code = tbl_row[k].ret_code;
          r.slot_granted_qos = tbl_row[k].qos;
          r.slot_topic_id    = tbl_row[k].topic;
        end
      endcase
    end
    return r;
  endfunction

  // Field by field comparison of one reply word against its prediction.
  task automatic check_reply(out_word_t got, out_word_t want);
    if (got.outcome !== want.outcome)
      report_mismatch($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
    if (got.found_slot !== want.found_slot)
      report_mismatch($sformatf("found_slot got %0d want %0d", got.found_slot, want.found_slot));
    if (got.slot_status !== want.slot_status)
      report_mismatch($sformatf("slot_status got %0d want %0d",
                                got.slot_status, want.slot_status));
    if (got.slot_return_code !== want.slot_return_code)
      report_mismatch($sformatf("slot_return_code got %h want %h",
                                got.slot_return_code, want.slot_return_code));
    if (got.slot_granted_qos !== want.slot_granted_qos)
      report_mismatch($sformatf("slot_granted_qos got %h want %h",
                                got.slot_granted_qos, want.slot_granted_qos));
    if (got.slot_topic_id !== want.slot_topic_id)
      report_mismatch($sformatf("slot_topic_id got %h want %h",
                                got.slot_topic_id, want.slot_topic_id));
  endtask

  // Both channels are sampled at the rising edge; replies are retired before new words enter.
  always @(posedge clk) begin : watch
    int k;
    if (!rst_n) begin
      for (k = 0; k < SLOTS; k++) begin
        tbl_row[k]  = ROW_RESET;
        tbl_used[k] = 1'b0;
      end
      expected_replies.delete();
    end else begin
      if (out_valid) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply word with no command outstanding");
        end else begin
          check_reply(out_word, expected_replies.pop_front());
        end
        reply_count = reply_count + 1;
      end
      if (start && !busy) begin
        expected_replies.push_back(predict_reply(in_word));
      end
    end
    waiting = expected_replies.size();
  end

endmodule

@@ tb/pending_reply_slot_table_top_test.sv @@
// Testbench top for the pending reply slot table: clock, reset, command words and verdict.
// Depends on prst_pkg, pending_reply_slot_table_top and prst_reply_checker.
module pending_reply_slot_table_top_test
  import prst_pkg::*;
();

  localparam int RANDOM_WORDS = 1350;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  int        mismatches;
  int        waiting;
  int        cycle_count;
  int        words_sent;

  // Type and id of recent acquires, so that lookups can hit.
  logic [7:0]  pool_type [8];
  logic [15:0] pool_id   [8];
  int          pool_next;

  pending_reply_slot_table_top #(.SLOT_COUNT(SLOT_COUNT_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  prst_reply_checker #(.SLOTS(SLOT_COUNT_DEF)) reply_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** pending_reply_slot_table_top: FAILED **");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic [2:0] cmd, logic [7:0] idx, logic [7:0] typ,
                                         logic [15:0] mid, logic [1:0] stat, logic [7:0] code,
                                         logic [7:0] qos, logic [15:0] topic);
    in_word_t w;
    w.command         = cmd;
    w.slot_index      = idx;
    w.message_type    = typ;
    w.message_id      = mid;
    w.new_status      = stat;
    w.new_return_code = code;
    w.new_granted_qos = qos;
    w.new_topic_id    = topic;
    return w;
  endfunction

  // Random command word: mostly in-range slots, lookups mostly aimed at recent acquires.
  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    int       p;
    w = make_word(CMD_READ, 8'($urandom_range(0, 7)), 8'($urandom), 16'($urandom),
                  2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 16'($urandom));
    if ($urandom_range(0, 99) < 15) w.slot_index = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 22) begin
      w.command = CMD_ACQUIRE;
      // A few types and ids repeat so that several slots can match one lookup.
      if ($urandom_range(0, 1) == 0) begin
        w.message_type = 8'($urandom_range(0, 3));
        w.message_id   = 16'($urandom_range(0, 3));
      end
    end else if (r < 44) begin
      w.command = CMD_LOOKUP;
      if ($urandom_range(0, 99) < 70) begin
        p = $urandom_range(0, 7);
        w.message_type = pool_type[p];
        w.message_id   = pool_id[p];
      end
    end else if (r < 54) w.command = CMD_SET_STATUS;
    else if (r < 61) w.command = CMD_SET_CODE;
    else if (r < 68) w.command = CMD_SET_QOS;
    else if (r < 75) w.command = CMD_SET_TOPIC;
    else if (r < 89) w.command = CMD_FREE;
    return w;
  endfunction

  // Random idle time before a word; every fifth stretch of fifty words runs back to back.
  task automatic pause_sender();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if ((words_sent / 50) % 5 == 4) gap = 0;
    else if (r < 45) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 12);
    else gap = $urandom_range(13, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Presents one word at a falling edge and returns at the falling edge after it is taken.
  task automatic send(in_word_t w);
    pause_sender();
    in_word <= w;
    start   <= 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (w.command == CMD_ACQUIRE) begin
      pool_type[pool_next] = w.message_type;
      pool_id[pool_next]   = w.message_id;
      pool_next            = (pool_next + 1) % 8;
    end
    words_sent = words_sent + 1;
  endtask

  initial begin
    int n;
    start      = 1'b0;
    in_word    = '0;
    rst_n      = 1'b0;
    words_sent = 0;
    pool_next  = 0;
    for (n = 0; n < 8; n++) begin
      pool_type[n] = '0;
      pool_id[n]   = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset contents and out-of-range reads.
    send(make_word(CMD_READ, 8'd0, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_READ, 8'd8, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_READ, 8'd255, 8'hFF, 16'hFFFF, 2'd3, 8'hFF, 8'hFF, 16'hFFFF));
    // A free slot never matches, even with the zero type and id it holds.
    send(make_word(CMD_LOOKUP, 8'd0, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));

    // Fill the table with extreme and random tags, then acquire once more on a full table.
    send(make_word(CMD_ACQUIRE, 8'd0, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_ACQUIRE, 8'd0, 8'hFF, 16'hFFFF, 2'd0, 8'h00, 8'h00, 16'h0000));
    for (n = 0; n < 6; n++) begin
      send(make_word(CMD_ACQUIRE, 8'($urandom), 8'($urandom), 16'($urandom),
                     2'd0, 8'h00, 8'h00, 16'h0000));
    end
    send(make_word(CMD_ACQUIRE, 8'd0, 8'h12, 16'h3456, 2'd0, 8'h00, 8'h00, 16'h0000));

    // A lookup hits until the slot stops awaiting.
    send(make_word(CMD_LOOKUP, 8'd0, 8'hFF, 16'hFFFF, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_SET_STATUS, 8'd1, 8'h00, 16'h0000, SS_SUCCESS, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_LOOKUP, 8'd0, 8'hFF, 16'hFFFF, 2'd0, 8'h00, 8'h00, 16'h0000));

    // Extreme context values, then a read of them.
    send(make_word(CMD_SET_CODE, 8'd2, 8'h00, 16'h0000, 2'd0, 8'hFF, 8'h00, 16'h0000));
    send(make_word(CMD_SET_QOS, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h80, 16'h0000));
    send(make_word(CMD_SET_TOPIC, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'hFFFF));
    send(make_word(CMD_SET_STATUS, 8'd2, 8'h00, 16'h0000, 2'd3, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_READ, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_SET_QOS, 8'd7, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h7F, 16'h0000));

    // Writes past the table change nothing.
    send(make_word(CMD_SET_STATUS, 8'd8, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_SET_CODE, 8'd255, 8'h00, 16'h0000, 2'd0, 8'hAA, 8'h00, 16'h0000));
    send(make_word(CMD_FREE, 8'd128, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));

    // Free twice, read the cleared slot, then reclaim it: the context stays zero.
    send(make_word(CMD_FREE, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_FREE, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_READ, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_ACQUIRE, 8'd0, 8'h5A, 16'hA5A5, 2'd0, 8'h00, 8'h00, 16'h0000));
    send(make_word(CMD_READ, 8'd2, 8'h00, 16'h0000, 2'd0, 8'h00, 8'h00, 16'h0000));

    // Random traffic.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      send(random_word());
    end
    start <= 1'b0;

    // Drain the outstanding replies, then allow for any late extra word.
    while (waiting != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("** pending_reply_slot_table_top: PASSED **");
    end else begin
      $display("** pending_reply_slot_table_top: FAILED **");
    end
    $finish;
  end

endmodule
